>>> design/sine_tone_note_generator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the note tone generator
// Shorthand for clocked implications checked on clock, gated by reset.
// ----------------------------------------------------------------------------
`ifndef SINE_TONE_NOTE_GENERATOR_TOP_MACROS_SVH
`define SINE_TONE_NOTE_GENERATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define STNG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define STNG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/stng_pkg.sv
// ----------------------------------------------------------------------------
// Note tone generator package
// Transfer types, function codes, volume scaling constants and the sine ROM.
// ----------------------------------------------------------------------------
package stng_pkg;

   // Function codes carried in req_type.func
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_STOP  = 2'd2;

   localparam int          TABLE_IDX_W = 8;
   localparam logic [7:0]  MIDSCALE    = 8'd128;
   localparam logic [6:0]  VOL_FULL    = 7'd100;

   // volume/100 as a fixed-point factor: vol * ceil(2^21 / 100)
   localparam int          VOL_FRAC        = 21;
   localparam int          VOL_SCALE_W     = 22;
   localparam logic [14:0] VOL_MULT        = 15'd20972;
   // full volume: 100 * 20972
   localparam logic [21:0] VOL_SCALE_RESET = 22'd2097200;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] freq_hz;
      logic [15:0] duration_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] dac_sample;
      logic       note_last;
   } rsp_type;

   // floor(127.5 * sin(k*pi/128)) for k = 0..64
   localparam logic [6:0] QUARTER_ROM [65] = '{
      7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,  7'd24,  7'd27,
      7'd30,  7'd34,  7'd37,  7'd39,  7'd42,  7'd45,  7'd48,  7'd51,  7'd54,  7'd57,
      7'd60,  7'd62,  7'd65,  7'd68,  7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd83,
      7'd85,  7'd87,  7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
      7'd106, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd115, 7'd116, 7'd117, 7'd118,
      7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124, 7'd125, 7'd125, 7'd126, 7'd126,
      7'd126, 7'd127, 7'd127, 7'd127, 7'd127
   };

   // Full-wave sine sample built from the quarter table by symmetry
   function automatic logic [7:0] sine_lookup(input logic [TABLE_IDX_W-1:0] idx);
      logic [6:0] j;
      logic [6:0] k;
      logic [7:0] q;
      logic [7:0] result;
      j = idx[6:0];
      // mirror the second quarter: 128 - j wraps to the same 7 bits
      k = (j <= 7'd64) ? j : (7'd0 - j);
      q = {1'b0, QUARTER_ROM[k]};
      priority if (!idx[7]) begin
         result = MIDSCALE + q;
      end else if (j == 7'd0) begin
         result = MIDSCALE;
      end else begin
         result = 8'd127 - q;
      end
      return result;
   endfunction

endpackage

>>> design/sine_tone_note_generator_top.sv
// ----------------------------------------------------------------------------
// Note tone generator
// Direct digital synthesis of note tones from a 65-entry quarter-wave sine ROM with volume.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_valid / req_stall     stng_pkg::req_type
//   rsp_      out        rsp_valid / rsp_stall     stng_pkg::rsp_type
//   csr_      in         csr_wr_en (no wait)       volume percent, 7 bits
//
// One item per cycle while the result is not stalled: each transfer is held in the
// input register, where a single pass of logic updates the note state and loads
// the result register, so a tick's sample passes both registers before it is offered.
// Reset is synchronous and leaves no note active at full volume.
// A stalled result holds the result register; the input register then holds
// only a tick, so start and stop items still pass while a sample waits.
//
module sine_tone_note_generator_top #(
   parameter int AUDIO_RATE      = 22050,
   parameter int PHASE_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  stng_pkg::req_type req_payload,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stng_pkg::rsp_type rsp_payload,

   input  logic              csr_wr_en,
   input  logic [6:0]        csr_wr_data
);

`include "sine_tone_note_generator_top_macros.svh"

   // Phase accumulator: 8 integer bits (the ROM index) over the fraction
   localparam int ACC_W = stng_pkg::TABLE_IDX_W + PHASE_FRAC_BITS;

   // Phase step = floor(freq * 2^ACC_W / AUDIO_RATE), done as a multiply by
   // ceil(2^(ACC_W+33) / AUDIO_RATE) and a shift by 33. The shift is large
   // enough that the rounding of the reciprocal never reaches the next integer
   // for any 16-bit frequency.
   localparam int          STEP_SHIFT     = 33;
   localparam int          STEP_MULT_W    = ACC_W + 21;
   localparam logic [95:0] STEP_MULT_FULL =
      ((96'd1 << (ACC_W + STEP_SHIFT)) + 96'(AUDIO_RATE) - 96'd1) / 96'(AUDIO_RATE);
   localparam int          STEP_PROD_W    = 16 + STEP_MULT_W;

   // Sample count = floor(ms * AUDIO_RATE / 1000) by the same reciprocal trick
   localparam int          CNT_SHIFT     = 26;
   localparam logic [63:0] CNT_MULT_FULL =
      ((64'(AUDIO_RATE) << CNT_SHIFT) + 64'd999) / 64'd1000;
   localparam int          CNT_MULT_W    = $clog2(CNT_MULT_FULL + 64'd1);
   localparam int          CNT_PROD_W    = 16 + CNT_MULT_W;
   localparam int          SAMPLES_W     =
      $clog2((64'd65535 * 64'(AUDIO_RATE)) / 64'd1000 + 64'd1);

   localparam int VOL_PROD_W = 8 + stng_pkg::VOL_SCALE_W;

   // ------------------------------------------------------------------------
   // Handshake and input register
   // ------------------------------------------------------------------------
   logic              s1_valid_ff, s1_valid_in;
   stng_pkg::req_type s1_item_ff;
   logic              s1_tick;
   logic              s1_start;
   logic              s1_stop;
   logic              s1_fire;
   logic              out_free;
   logic              req_take;

   logic              rsp_valid_ff, rsp_valid_in;
   stng_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   assign s1_tick  = (s1_item_ff.func == stng_pkg::FUNC_TICK);
   assign s1_start = (s1_item_ff.func == stng_pkg::FUNC_START);
   assign s1_stop  = (s1_item_ff.func == stng_pkg::FUNC_STOP);

   // The result register frees up when empty or when its sample transfers now
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // Only a tick needs the result register; other codes always retire
   assign s1_fire  = s1_valid_ff && (!s1_tick || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = (s1_fire && s1_tick) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_payload;
      end
      if (s1_fire && s1_tick) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ------------------------------------------------------------------------
   // Volume register, kept as a ready-made fixed-point scale factor
   // ------------------------------------------------------------------------
   logic [stng_pkg::VOL_SCALE_W-1:0] vol_scale_ff, vol_scale_in;
   logic [6:0]                       vol_sat;

   // Saturate anything above full volume
   assign vol_sat      = (csr_wr_data > stng_pkg::VOL_FULL) ? stng_pkg::VOL_FULL : csr_wr_data;
   assign vol_scale_in = {15'd0, vol_sat} * {7'd0, stng_pkg::VOL_MULT};

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_scale_ff <= stng_pkg::VOL_SCALE_RESET;
      end else if (csr_wr_en) begin
         vol_scale_ff <= vol_scale_in;
      end
   end

   // ------------------------------------------------------------------------
   // Note state
   // ------------------------------------------------------------------------
   logic [ACC_W-1:0]     phase_acc_ff,    phase_acc_in;
   logic [ACC_W-1:0]     phase_step_ff,   phase_step_in;
   logic [SAMPLES_W-1:0] samples_left_ff, samples_left_in;
   logic                 rest_flag_ff,    rest_flag_in;

   // Start: phase step and sample count from the incoming note
   logic [STEP_PROD_W-1:0] step_prod;
   logic [CNT_PROD_W-1:0]  cnt_prod;

   assign step_prod = {{STEP_MULT_W{1'b0}}, s1_item_ff.freq_hz}
                    * {16'd0, STEP_MULT_FULL[STEP_MULT_W-1:0]};
   assign cnt_prod  = {{CNT_MULT_W{1'b0}}, s1_item_ff.duration_ms}
                    * {16'd0, CNT_MULT_FULL[CNT_MULT_W-1:0]};

   // Tick: ROM read at the integer phase, then scale toward midscale
   logic [7:0]            raw_sample;
   logic [7:0]            delta;
   logic [VOL_PROD_W-1:0] vol_prod;
   logic [7:0]            mag;
   logic [7:0]            scaled;
   logic                  note_active;

   assign note_active = (samples_left_ff != '0);
   assign raw_sample  = rest_flag_ff ? stng_pkg::MIDSCALE
                      : stng_pkg::sine_lookup(phase_acc_ff[ACC_W-1 -: stng_pkg::TABLE_IDX_W]);
   // Distance from midscale; bit 7 tells the half
   assign delta    = raw_sample[7] ? (raw_sample - stng_pkg::MIDSCALE)
                                   : (stng_pkg::MIDSCALE - raw_sample);
   assign vol_prod = {{stng_pkg::VOL_SCALE_W{1'b0}}, delta} * {8'd0, vol_scale_ff};
   assign mag      = vol_prod[stng_pkg::VOL_FRAC +: 8];
   assign scaled   = raw_sample[7] ? (stng_pkg::MIDSCALE + mag) : (stng_pkg::MIDSCALE - mag);

   always_comb begin
      phase_acc_in    = phase_acc_ff;
      phase_step_in   = phase_step_ff;
      samples_left_in = samples_left_ff;
      rest_flag_in    = rest_flag_ff;
      rsp_payload_in.dac_sample = stng_pkg::MIDSCALE;
      rsp_payload_in.note_last  = 1'b1;

      if (s1_fire) begin
         priority if (s1_start) begin
            if (s1_item_ff.duration_ms == 16'd0) begin
               // zero length ends the sequence: drop any active note
               samples_left_in = '0;
            end else begin
               phase_acc_in    = '0;
               phase_step_in   = step_prod[STEP_SHIFT +: ACC_W];
               samples_left_in = cnt_prod[CNT_SHIFT +: SAMPLES_W];
               rest_flag_in    = (s1_item_ff.freq_hz == 16'd0);
            end
         end else if (s1_stop) begin
            samples_left_in = '0;
         end else if (s1_tick && note_active) begin
            rsp_payload_in.dac_sample = scaled;
            rsp_payload_in.note_last  = (samples_left_ff == SAMPLES_W'(1));
            // advance phase, wrapping modulo the table
            phase_acc_in    = phase_acc_ff + phase_step_ff;
            samples_left_in = samples_left_ff - SAMPLES_W'(1);
         end else begin
            // idle tick keeps the midscale default; unused code does nothing
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff    <= '0;
         phase_step_ff   <= '0;
         samples_left_ff <= '0;
         rest_flag_ff    <= 1'b0;
      end else begin
         phase_acc_ff    <= phase_acc_in;
         phase_step_ff   <= phase_step_in;
         samples_left_ff <= samples_left_in;
         rest_flag_ff    <= rest_flag_in;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `STNG_ASSERT_NOW(a_stall_holds_item, req_stall, s1_valid_ff && s1_tick, "stall without a held tick")

   `STNG_ASSERT_NEXT(a_idle_tick_midscale, s1_fire && s1_tick && !note_active, rsp_valid && rsp_payload.dac_sample == stng_pkg::MIDSCALE && rsp_payload.note_last, "idle tick not midscale with last")

   `STNG_ASSERT_NEXT(a_rest_is_silent, s1_fire && s1_tick && note_active && rest_flag_ff, rsp_valid && rsp_payload.dac_sample == stng_pkg::MIDSCALE, "rest note produced a tone")

   `STNG_ASSERT_NEXT(a_stop_ends_note, s1_fire && s1_stop, samples_left_ff == '0, "stop left a note active")

endmodule
